// ===== rtl/core/uart_register_datagram_engine_defines.svh =====
// Assertion macros shared by the datagram engine RTL.
`ifndef UART_REGISTER_DATAGRAM_ENGINE_DEFINES_SVH
`define UART_REGISTER_DATAGRAM_ENGINE_DEFINES_SVH
`ifndef SYNTH
// Antecedent in one cycle implies consequent in the next.
`define URDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
// Condition holds at every clock edge out of reset.
`define URDE_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed: invariant");
`else
`define URDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define URDE_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/core/urde_pkg.sv =====
// Types, constants and CRC helper for the UART register datagram engine.
package urde_pkg;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_RX    = 2'd2;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] REPLY_ADDR = 8'hFF;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam int WIN_DEPTH = 8;
    localparam logic [3:0] READ_LEN  = 4'd4;
    localparam logic [3:0] WRITE_LEN = 4'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  node_addr;
        logic [7:0]  reg_addr;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [7:0]  reply_reg;
        logic [31:0] reply_data;
    } out_item_t;

    // One window cell: byte and CRC of the bytes from it to the newest.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] crc;
    } cell_t;

    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [7:0] rx_byte;
    } cell_ctl_t;

    // Load command for the transmit sequencer.
    typedef struct packed {
        logic            tx_req;
        logic [3:0]      tx_len;
        logic [6:0][7:0] tx_bytes;
        logic            reply_req;
        logic [7:0]      reply_reg;
        logic [31:0]     reply_data;
    } tx_load_t;

    // CRC8, one byte, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/uart_register_datagram_engine.sv =====
// Top level of the UART register datagram engine: receive cell chain and control.
//
//  channel | direction | ports                     | carries
//  --------+-----------+---------------------------+-------------------------------
//  s_      | in        | s_valid s_ready s_item    | read/write request or rx byte
//  m_      | out       | m_valid m_ready m_item    | tx datagram bytes or reply
//
// A read request yields 4 output transactions, a write request 8, one per cycle
// unless m_ready stalls; the sequencer's byte shift line sets that pace, and a new
// request is taken on the cycle its predecessor's final byte moves into the output
// register. A received byte produces no output; a matching reply costs one output slot.
// Reset (aresetn low, synchronous) clears the search and all pending output.
// Stalls on m_ready hold the output register and back up into s_ready.
`include "uart_register_datagram_engine_defines.svh"

module uart_register_datagram_engine #(
    parameter int SCAN_LIMIT = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  urde_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output urde_pkg::out_item_t m_item
);

    // Byte counter only has to reach SCAN_LIMIT: the search disarms there.
    localparam int SEEN_W = $clog2(SCAN_LIMIT + 1);

    logic accept;
    logic act_read, act_write, act_rx;
    logic match;

    logic              armed_reg, armed_next;
    logic [7:0]        tgt_reg, tgt_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [SEEN_W-1:0] seen_inc;

    urde_pkg::cell_ctl_t cell_ctl;
    urde_pkg::cell_t     cells [urde_pkg::WIN_DEPTH];
    urde_pkg::tx_load_t  ld;

    assign accept    = s_valid && s_ready;
    assign act_read  = accept && (s_item.action == urde_pkg::ACT_READ);
    assign act_write = accept && (s_item.action == urde_pkg::ACT_WRITE);
    // Bytes arriving while not searching are dropped.
    assign act_rx    = accept && (s_item.action == urde_pkg::ACT_RX) && armed_reg;

    assign seen_inc = seen_reg + SEEN_W'(1);

    // Window chain: cell 0 oldest, cell 7 newest. Each cell keeps the CRC of
    // the bytes from itself up to the newest, so before the shift cell 1 holds
    // the CRC of the seven bytes that precede the incoming CRC byte.
    assign cell_ctl.shift   = act_rx;
    assign cell_ctl.clear   = act_read;
    assign cell_ctl.rx_byte = s_item.rx_byte;

    for (genvar j = 0; j < urde_pkg::WIN_DEPTH; j++) begin : g_cell
        urde_pkg::cell_t nbr;
        if (j == urde_pkg::WIN_DEPTH - 1) begin : g_head
            assign nbr = '{data: s_item.rx_byte, crc: 8'h00};
        end else begin : g_link
            assign nbr = cells[j+1];
        end
        urde_rx_cell u_cell (
            .aclk   (aclk),
            .ctl    (cell_ctl),
            .nbr_i  (nbr),
            .cell_o (cells[j])
        );
    end

    // Check the window as it will stand after this byte shifts in.
    assign match = act_rx
                && (seen_reg >= SEEN_W'(urde_pkg::WIN_DEPTH - 1))
                && (cells[1].data == urde_pkg::SYNC_BYTE)
                && (cells[2].data == urde_pkg::REPLY_ADDR)
                && (cells[3].data == tgt_reg)
                && (cells[1].crc == s_item.rx_byte);

    always_comb begin
        armed_next = armed_reg;
        tgt_next   = tgt_reg;
        seen_next  = seen_reg;
        if (act_read) begin
            armed_next = 1'b1;
            tgt_next   = s_item.reg_addr;
            seen_next  = '0;
        end else if (act_write) begin
            armed_next = 1'b0;
        end else if (act_rx) begin
            seen_next = seen_inc;
            if (match || (seen_inc >= SEEN_W'(SCAN_LIMIT))) begin
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            tgt_reg   <= 8'h00;
            seen_reg  <= '0;
        end else begin
            armed_reg <= armed_next;
            tgt_reg   <= tgt_next;
            seen_reg  <= seen_next;
        end
    end

    // Datagram build; CRC is appended by the sequencer as bytes go out.
    always_comb begin
        ld = '0;
        if (act_read || act_write) begin
            ld.tx_req      = 1'b1;
            ld.tx_len      = act_write ? urde_pkg::WRITE_LEN : urde_pkg::READ_LEN;
            ld.tx_bytes[0] = urde_pkg::SYNC_BYTE;
            ld.tx_bytes[1] = {6'b0, s_item.node_addr}
                           | (act_write ? urde_pkg::WRITE_FLAG : 8'h00);
            ld.tx_bytes[2] = s_item.reg_addr;
            ld.tx_bytes[3] = s_item.write_data[31:24];
            ld.tx_bytes[4] = s_item.write_data[23:16];
            ld.tx_bytes[5] = s_item.write_data[15:8];
            ld.tx_bytes[6] = s_item.write_data[7:0];
        end
        ld.reply_req  = match;
        ld.reply_reg  = tgt_reg;
        ld.reply_data = {cells[4].data, cells[5].data, cells[6].data, cells[7].data};
    end

    urde_tx_seq u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ld      (ld),
        .idle_o  (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    `URDE_ASSERT_NEXT(a_match_disarms, aclk, aresetn, match, !armed_reg)
    `URDE_ASSERT_NEXT(a_read_arms, aclk, aresetn, act_read, armed_reg && (seen_reg == '0))
    `URDE_ASSERT_NEXT(a_write_busy, aclk, aresetn, act_write, !armed_reg && !s_ready)
    `URDE_ASSERT_ALWAYS(a_seen_bound, aclk, aresetn, seen_reg <= SEEN_W'(SCAN_LIMIT))

endmodule

// ===== rtl/core/urde_rx_cell.sv =====
// One receive window cell: holds a byte and its running CRC.
module urde_rx_cell (
    input  logic               aclk,
    input  urde_pkg::cell_ctl_t ctl,
    input  urde_pkg::cell_t    nbr_i,
    output urde_pkg::cell_t    cell_o
);

    urde_pkg::cell_t cell_reg;
    urde_pkg::cell_t cell_next;

    always_comb begin
        cell_next = cell_reg;
        if (ctl.clear) begin
            cell_next = '0;
        end else if (ctl.shift) begin
            cell_next.data = nbr_i.data;
            cell_next.crc  = urde_pkg::crc8_step(nbr_i.crc, ctl.rx_byte);
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    assign cell_o = cell_reg;

endmodule

// ===== rtl/core/urde_tx_seq.sv =====
// Transmit sequencer: byte shift line, CRC accumulator, reply slot, output register.
module urde_tx_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  urde_pkg::tx_load_t   ld,
    output logic                 idle_o,
    output logic                 m_valid,
    input  logic                 m_ready,
    output urde_pkg::out_item_t  m_item
);

    logic [6:0][7:0]     byte_reg, byte_next;
    logic [3:0]          left_reg, left_next;
    logic [7:0]          crc_reg, crc_next;
    logic                rpend_reg, rpend_next;
    logic [7:0]          rreg_reg, rreg_next;
    logic [31:0]         rdata_reg, rdata_next;
    logic                m_valid_reg, m_valid_next;
    urde_pkg::out_item_t m_item_reg, m_item_next;

    logic slot, have, pop, final_pop;

    assign slot      = !m_valid_reg || m_ready;
    assign have      = (left_reg != 4'd0) || rpend_reg;
    assign pop       = slot && have;
    // CRC byte or reply leaving: the sequencer is free at this edge
    assign final_pop = pop && (left_reg <= 4'd1);
    assign idle_o    = !have || final_pop;

    always_comb begin
        byte_next    = byte_reg;
        left_next    = left_reg;
        crc_next     = crc_reg;
        rpend_next   = rpend_reg;
        rreg_next    = rreg_reg;
        rdata_next   = rdata_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        if (slot) begin
            m_valid_next = have;
        end
        if (pop) begin
            m_item_next = '0;
            if (left_reg != 4'd0) begin
                m_item_next.kind    = urde_pkg::KIND_TX;
                m_item_next.tx_byte = (left_reg == 4'd1) ? crc_reg : byte_reg[0];
                m_item_next.last    = (left_reg == 4'd1);
                left_next           = left_reg - 4'd1;
                crc_next            = urde_pkg::crc8_step(crc_reg, byte_reg[0]);
                byte_next           = {8'h00, byte_reg[6:1]};
            end else begin
                m_item_next.kind       = urde_pkg::KIND_REPLY;
                m_item_next.last       = 1'b1;
                m_item_next.reply_reg  = rreg_reg;
                m_item_next.reply_data = rdata_reg;
                rpend_next             = 1'b0;
            end
        end

        if (ld.tx_req) begin
            left_next = ld.tx_len;
            byte_next = ld.tx_bytes;
            crc_next  = 8'h00;
        end
        if (ld.reply_req) begin
            rpend_next = 1'b1;
            rreg_next  = ld.reply_reg;
            rdata_next = ld.reply_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= 4'd0;
            rpend_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            left_reg    <= left_next;
            rpend_reg   <= rpend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        crc_reg    <= crc_next;
        rreg_reg   <= rreg_next;
        rdata_reg  <= rdata_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== tb/sv/uart_register_datagram_engine_test.sv =====
// Self-checking testbench for the UART register datagram engine: requests, reply search, scan limit.
module uart_register_datagram_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_LIMIT = 20;
    // Run limit; the slowest legal run is well under a tenth of this.
    localparam int TIMEOUT_NS = 2_000_000;
    // Input transactions to send in total.
    localparam int ITEM_TARGET = 230;

    // Action code the engine must drop without a trace.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Ways a reply frame on the line can be damaged.
    localparam int FLAW_NONE = 0;
    localparam int FLAW_CRC  = 1;
    localparam int FLAW_REG  = 2;
    localparam int FLAW_HDR  = 3;
    localparam int FLAW_CUT  = 4;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    urde_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    urde_pkg::out_item_t m_item;

    uart_register_datagram_engine #(
        .SCAN_LIMIT(SCAN_LIMIT)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the engine state, kept in step with accepted input
    // transactions.
    // ------------------------------------------------------------------
    logic [7:0] scan_win [8];   // receive window, entry 0 oldest
    logic [7:0] target_reg  = '0;
    bit         hunting     = 1'b0;
    logic [4:0] rx_count    = '0;

    // Results the engine still owes, oldest first.
    urde_pkg::out_item_t awaited_out [$];
    urde_pkg::out_item_t want;

    int         err_count    = 0;
    int         sent_items   = 0;   // accepted input transactions
    int         burst_left   = 0;
    bit         tx_gaps_on   = 1'b0;
    bit         rx_stall_on  = 1'b0;
    logic [15:0] stall_mask  = 16'hFFFF;
    logic [3:0]  stall_phase = '0;

    initial begin
        for (int i = 0; i < 8; i++) scan_win[i] = '0;
    end

    // CRC8 (x^8+x^2+x+1), bit-serial, MSB first, zero seed.
    function automatic logic [7:0] crc8_calc(input logic [7:0] bytes [8], input int n);
        logic [7:0] c;
        logic       fb;
        c = '0;
        for (int i = 0; i < n; i++) begin
            for (int b = 7; b >= 0; b--) begin
                fb = c[7] ^ bytes[i][b];
                c  = {c[6:0], 1'b0} ^ (fb ? urde_pkg::CRC_POLY : 8'h00);
            end
        end
        return c;
    endfunction

    function automatic urde_pkg::out_item_t tx_result(input logic [7:0] b, input bit is_last);
        return '{kind: urde_pkg::KIND_TX, tx_byte: b, last: is_last, reply_reg: 8'h00,
                 reply_data: 32'h0};
    endfunction

    // Works out what one accepted transaction makes the engine emit and
    // queues it. Returns 1 when the transaction was not simply dropped.
    function automatic bit frame_and_scan(input urde_pkg::in_item_t it);
        logic [7:0] frame [8];
        for (int i = 0; i < 8; i++) frame[i] = '0;
        case (it.action)
            urde_pkg::ACT_READ: begin
                frame[0] = urde_pkg::SYNC_BYTE;
                frame[1] = {6'b0, it.node_addr};
                frame[2] = it.reg_addr;
                frame[3] = crc8_calc(frame, 3);
                for (int i = 0; i < 4; i++) awaited_out.push_back(tx_result(frame[i], i == 3));
                // a read re-arms the hunt from a clean window
                target_reg = it.reg_addr;
                hunting    = 1'b1;
                rx_count   = '0;
                for (int i = 0; i < 8; i++) scan_win[i] = '0;
                return 1'b1;
            end
            urde_pkg::ACT_WRITE: begin
                frame[0] = urde_pkg::SYNC_BYTE;
                frame[1] = urde_pkg::WRITE_FLAG | {6'b0, it.node_addr};
                frame[2] = it.reg_addr;
                frame[3] = it.write_data[31:24];
                frame[4] = it.write_data[23:16];
                frame[5] = it.write_data[15:8];
                frame[6] = it.write_data[7:0];
                frame[7] = crc8_calc(frame, 7);
                for (int i = 0; i < 8; i++) awaited_out.push_back(tx_result(frame[i], i == 7));
                // window and count survive, only the hunt stops
                hunting = 1'b0;
                return 1'b1;
            end
            urde_pkg::ACT_RX: begin
                if (!hunting) return 1'b0;
                for (int i = 0; i < 7; i++) scan_win[i] = scan_win[i + 1];
                scan_win[7] = it.rx_byte;
                rx_count    = rx_count + 5'd1;
                if (rx_count >= 5'd8 && scan_win[0] == urde_pkg::SYNC_BYTE &&
                    scan_win[1] == urde_pkg::REPLY_ADDR &&
                    scan_win[2] == target_reg && crc8_calc(scan_win, 7) == scan_win[7]) begin
                    awaited_out.push_back('{kind: urde_pkg::KIND_REPLY, tx_byte: 8'h00,
                        last: 1'b1, reply_reg: target_reg,
                        reply_data: {scan_win[3], scan_win[4], scan_win[5], scan_win[6]}});
                    hunting = 1'b0;
                end else if (rx_count >= SCAN_LIMIT) begin
                    hunting = 1'b0;
                end
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transaction per call, bursts with random gaps when tx_gaps_on.
    // Called from a rising-edge time step; valid stays up across a burst.
    // ------------------------------------------------------------------
    task automatic send_item(input urde_pkg::in_item_t it);
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        void'(frame_and_scan(it));
        sent_items++;
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Request transaction; unused fields carry noise.
    function automatic urde_pkg::in_item_t req_item(input logic [1:0] act,
                                                    input logic [1:0] node,
                                                    input logic [7:0] regn,
                                                    input logic [31:0] data);
        urde_pkg::in_item_t it;
        it.action     = act;
        it.node_addr  = node;
        it.reg_addr   = regn;
        it.write_data = data;
        it.rx_byte    = 8'($urandom);
        return it;
    endfunction

    function automatic urde_pkg::in_item_t rx_item(input logic [7:0] b);
        urde_pkg::in_item_t it;
        it.action     = urde_pkg::ACT_RX;
        it.node_addr  = 2'($urandom);
        it.reg_addr   = 8'($urandom);
        it.write_data = $urandom;
        it.rx_byte    = b;
        return it;
    endfunction

    // Puts a reply frame for regn on the line, damaged as flaw says.
    task automatic send_reply(input logic [7:0] regn, input logic [31:0] data, input int flaw);
        logic [7:0] frame [8];
        int         n;
        n        = 8;
        frame[0] = urde_pkg::SYNC_BYTE;
        frame[1] = urde_pkg::REPLY_ADDR;
        frame[2] = regn;
        frame[3] = data[31:24];
        frame[4] = data[23:16];
        frame[5] = data[15:8];
        frame[6] = data[7:0];
        frame[7] = '0;
        case (flaw)
            FLAW_REG: begin
                frame[2] = regn ^ 8'($urandom_range(1, 255));
            end
            FLAW_HDR: begin
                if ($urandom_range(0, 1))
                    frame[0] = urde_pkg::SYNC_BYTE ^ 8'($urandom_range(1, 255));
                else
                    frame[1] = urde_pkg::REPLY_ADDR ^ 8'($urandom_range(1, 255));
            end
            FLAW_CUT: begin
                n = $urandom_range(1, 7);
            end
            default: begin
            end
        endcase
        frame[7] = crc8_calc(frame, 7);
        if (flaw == FLAW_CRC) frame[7] = frame[7] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < n; i++) send_item(rx_item(frame[i]));
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern reloaded as stall_phase wraps, about 3/4 ready when rx_stall_on.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_phase == 4'd15) stall_mask <= 16'($urandom | $urandom);
        stall_phase <= stall_phase + 4'd1;
        m_ready     <= !rx_stall_on || stall_mask[stall_phase];
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (err_count < 60)
            $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
        err_count++;
    endtask

    // Every output transaction is matched against the oldest awaited result.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_out.size() == 0) begin
                report_mismatch("output transaction with none awaited",
                                32'(m_item.tx_byte), 32'h0);
            end else begin
                want = awaited_out.pop_front();
                if (m_item.kind !== want.kind)
                    report_mismatch("kind", 32'(m_item.kind), 32'(want.kind));
                if (m_item.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 32'(m_item.tx_byte), 32'(want.tx_byte));
                if (m_item.last !== want.last)
                    report_mismatch("last", 32'(m_item.last), 32'(want.last));
                if (m_item.reply_reg !== want.reply_reg)
                    report_mismatch("reply_reg", 32'(m_item.reply_reg), 32'(want.reply_reg));
                if (m_item.reply_data !== want.reply_data)
                    report_mismatch("reply_data", m_item.reply_data, want.reply_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Request framing at the field extremes, plus traffic that must vanish.
    task automatic test_request_framing();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        send_item(req_item(urde_pkg::ACT_READ, 2'd0, 8'h00, $urandom));
        send_item(req_item(urde_pkg::ACT_READ, 2'd3, 8'hFF, $urandom));
        send_item(req_item(urde_pkg::ACT_WRITE, 2'd0, 8'h00, 32'h0000_0000));
        send_item(req_item(urde_pkg::ACT_WRITE, 2'd3, 8'hFF, 32'hFFFF_FFFF));
        send_item(req_item(urde_pkg::ACT_WRITE, 2'd2, 8'h5A, 32'h1234_5678));
        // unused action code and a line byte while nobody is listening
        send_item(req_item(ACT_UNUSED, 2'd1, 8'hA5, $urandom));
        send_item(rx_item(8'h05));
    endtask

    // Read, clean reply, then a stray byte after the hunt has closed.
    task automatic test_reply_capture();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        send_item(req_item(urde_pkg::ACT_READ, 2'd1, 8'h6C, $urandom));
        send_reply(8'h6C, 32'hDEAD_BEEF, FLAW_NONE);
        send_item(rx_item(8'hFF));
    endtask

    // A write between a read and the next line byte must cancel the hunt.
    task automatic test_write_disarm();
        send_item(req_item(urde_pkg::ACT_READ, 2'd2, 8'h20, $urandom));
        send_item(req_item(urde_pkg::ACT_WRITE, 2'd2, 8'h20, $urandom));
        send_item(rx_item(8'h00));
    endtask

    // Mostly read-then-reply exchanges with noise in front and damaged
    // frames now and then; noise and frame together can run past the scan limit.
    task automatic test_random_traffic();
        int         pick;
        int         flaw;
        int         round;
        logic [7:0] regn;
        logic [7:0] b;
        logic [31:0] data;
        round = 0;
        while (sent_items < ITEM_TARGET) begin
            // change the idling mix every few exchanges, including none at all
            if (round % 12 == 0) begin
                tx_gaps_on  = 1'($urandom_range(0, 1));
                rx_stall_on = 1'($urandom_range(0, 1));
            end
            round++;
            pick = $urandom_range(0, 99);
            regn = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 1) * 8'hFF) : 8'($urandom);
            case ($urandom_range(0, 5))
                0:       data = 32'h0;
                1:       data = 32'hFFFF_FFFF;
                default: data = $urandom;
            endcase
            if (pick < 55) begin
                send_item(req_item(urde_pkg::ACT_READ, 2'($urandom), regn, $urandom));
                repeat ($urandom_range(0, 14)) begin
                    case ($urandom_range(0, 7))
                        0:       b = urde_pkg::SYNC_BYTE;
                        1:       b = urde_pkg::REPLY_ADDR;
                        default: b = 8'($urandom);
                    endcase
                    send_item(rx_item(b));
                end
                case ($urandom_range(0, 19))
                    0, 1, 2:  flaw = FLAW_CRC;
                    3, 4:     flaw = FLAW_REG;
                    5, 6:     flaw = FLAW_HDR;
                    7:        flaw = FLAW_CUT;
                    default:  flaw = FLAW_NONE;
                endcase
                send_reply(regn, data, flaw);
                // a second clean frame must not be reported twice
                if ($urandom_range(0, 3) == 0) send_reply(regn, $urandom, FLAW_NONE);
            end else if (pick < 70) begin
                send_item(req_item(urde_pkg::ACT_WRITE, 2'($urandom), regn, data));
            end else if (pick < 80) begin
                send_item(req_item(urde_pkg::ACT_READ, 2'($urandom), regn, $urandom));
                send_item(req_item(urde_pkg::ACT_WRITE, 2'($urandom), 8'($urandom), $urandom));
                send_reply(regn, data, FLAW_NONE);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) send_item(rx_item(8'($urandom)));
            end else begin
                send_item(req_item(ACT_UNUSED, 2'($urandom), 8'($urandom), $urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, tests in turn, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_request_framing();
        test_reply_capture();
        test_write_disarm();
        test_random_traffic();

        // drop valid in the step of the last accept so nothing is taken twice
        s_valid <= 1'b0;
        rx_stall_on = 1'b0;
        while (awaited_out.size() != 0) @(posedge aclk);
        // room for anything unexpected still in the pipe
        repeat (24) @(posedge aclk);

        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/urde_pkg.sv
rtl/core/urde_rx_cell.sv
rtl/core/urde_tx_seq.sv
rtl/core/uart_register_datagram_engine.sv
tb/sv/uart_register_datagram_engine_test.sv
